// File: hdl/jtl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jtl_pkg
// Shared types, token codes and character helpers of the JSON token lexer.
// ----------------------------------------------------------------------------
package jtl_pkg;

	localparam logic [2:0] KIND_STR  = 3'd0;
	localparam logic [2:0] KIND_NUM  = 3'd1;
	localparam logic [2:0] KIND_BOOL = 3'd2;
	localparam logic [2:0] KIND_NULL = 3'd3;
	localparam logic [2:0] KIND_OP   = 3'd4;
	localparam logic [2:0] KIND_END  = 3'd5;
	localparam logic [2:0] KIND_ERR  = 3'd6;

	localparam logic [1:0] GUESS_TRUE  = 2'd0;
	localparam logic [1:0] GUESS_FALSE = 2'd1;
	localparam logic [1:0] GUESS_NULL  = 2'd2;

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSL   = 8'h5C;

	typedef struct packed {
		logic [2:0] token_kind;
		logic       has_char;
		logic [7:0] char_byte;
		logic       token_last;
		logic       bool_value;
	} res_t;

	typedef struct packed {
		logic two;
		res_t r0;
		res_t r1;
	} qent_t;

	function automatic res_t mk_res(logic [2:0] kind, logic has, logic [7:0] ch,
		logic last, logic bv);
		res_t r;
		r.token_kind = kind;
		r.has_char   = has;
		r.char_byte  = has ? ch : 8'h00;
		r.token_last = last;
		r.bool_value = bv;
		return r;
	endfunction

	function automatic logic [2:0] word_len(logic [1:0] g);
		logic [2:0] l;
		unique case (g)
			GUESS_TRUE:  l = 3'd4;
			GUESS_FALSE: l = 3'd5;
			GUESS_NULL:  l = 3'd4;
			default:     l = 3'd0;
		endcase
		return l;
	endfunction

	function automatic logic [7:0] word_char(logic [1:0] g, logic [2:0] idx);
		logic [7:0] ch;
		ch = 8'h00;
		unique case (g)
			GUESS_TRUE: begin
				unique case (idx)
					3'd0: ch = "t";
					3'd1: ch = "r";
					3'd2: ch = "u";
					3'd3: ch = "e";
					default: ch = 8'h00;
				endcase
			end
			GUESS_FALSE: begin
				unique case (idx)
					3'd0: ch = "f";
					3'd1: ch = "a";
					3'd2: ch = "l";
					3'd3: ch = "s";
					3'd4: ch = "e";
					default: ch = 8'h00;
				endcase
			end
			GUESS_NULL: begin
				unique case (idx)
					3'd0: ch = "n";
					3'd1: ch = "u";
					3'd2: ch = "l";
					3'd3: ch = "l";
					default: ch = 8'h00;
				endcase
			end
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	function automatic logic is_digit(logic [7:0] c);
		return (c >= "0") && (c <= "9");
	endfunction

	function automatic logic is_lower(logic [7:0] c);
		return (c >= "a") && (c <= "z");
	endfunction

	function automatic logic is_space(logic [7:0] c);
		return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
	endfunction

	function automatic logic num_cont(logic [7:0] c);
		return is_digit(c) || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F")) ||
			(c == ".") || (c == "+") || (c == "-");
	endfunction

	function automatic logic is_op(logic [7:0] c);
		return (c == "{") || (c == "}") || (c == "[") || (c == "]") ||
			(c == ":") || (c == ",");
	endfunction

endpackage
`default_nettype wire

// File: hdl/jtl_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jtl_front
// Lexer state machine: classifies each byte and builds the results it causes.
// ----------------------------------------------------------------------------
module jtl_front (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            in_accept,
	input  wire [7:0]      in_byte,
	input  wire            in_end,
	output logic           push,
	output jtl_pkg::qent_t entry
);
	import jtl_pkg::*;

	localparam logic [2:0] MODE_IDLE = 3'd0;
	localparam logic [2:0] MODE_STR  = 3'd1;
	localparam logic [2:0] MODE_ESC  = 3'd2;
	localparam logic [2:0] MODE_NUM  = 3'd3;
	localparam logic [2:0] MODE_WORD = 3'd4;

	logic [2:0] mode_q, mode_d;
	logic [1:0] guess_q, guess_d;
	logic [2:0] len_q, len_d;
	logic       mis_q, mis_d;

	logic       fr_has;
	res_t       fr_res;
	logic [2:0] fr_mode;
	logic       fr_word;
	res_t       word_res;
	logic       word_ok;

	always_comb begin
		fr_has  = 1'b0;
		fr_res  = '0;
		fr_mode = MODE_IDLE;
		fr_word = 1'b0;
		priority if (is_space(in_byte)) begin
			fr_mode = MODE_IDLE;
		end else if (in_byte == CH_QUOTE) begin
			fr_mode = MODE_STR;
		end else if ((in_byte == "+") || (in_byte == "-") || is_digit(in_byte)) begin
			fr_mode = MODE_NUM;
			fr_has  = 1'b1;
			fr_res  = mk_res(KIND_NUM, 1'b1, in_byte, 1'b0, 1'b0);
		end else if ((in_byte == "t") || (in_byte == "f") || (in_byte == "n")) begin
			fr_mode = MODE_WORD;
			fr_word = 1'b1;
		end else if (is_op(in_byte)) begin
			fr_has = 1'b1;
			fr_res = mk_res(KIND_OP, 1'b1, in_byte, 1'b1, 1'b0);
		end else begin
			fr_has = 1'b1;
			fr_res = mk_res(KIND_ERR, 1'b0, 8'h00, 1'b1, 1'b0);
		end
	end

	always_comb begin
		word_ok = !mis_q && (len_q == word_len(guess_q)) && (guess_q != 2'd3);
		priority if (!word_ok) begin
			word_res = mk_res(KIND_ERR, 1'b0, 8'h00, 1'b1, 1'b0);
		end else if (guess_q == GUESS_NULL) begin
			word_res = mk_res(KIND_NULL, 1'b0, 8'h00, 1'b1, 1'b0);
		end else begin
			word_res = mk_res(KIND_BOOL, 1'b0, 8'h00, 1'b1, guess_q == GUESS_TRUE);
		end
	end

	always_comb begin
		logic fresh;
		logic n1;
		fresh   = 1'b0;
		n1      = 1'b0;
		mode_d  = mode_q;
		guess_d = guess_q;
		len_d   = len_q;
		mis_d   = mis_q;
		entry   = '0;
		push    = 1'b0;
		if (in_end) begin
			mode_d = MODE_IDLE;
			push   = 1'b1;
			unique case (mode_q)
				MODE_STR, MODE_ESC: begin
					entry.r0 = mk_res(KIND_ERR, 1'b0, 8'h00, 1'b1, 1'b0);
				end
				MODE_NUM: begin
					entry.r0  = mk_res(KIND_NUM, 1'b0, 8'h00, 1'b1, 1'b0);
					entry.r1  = mk_res(KIND_END, 1'b0, 8'h00, 1'b1, 1'b0);
					entry.two = 1'b1;
				end
				MODE_WORD: begin
					entry.r0  = word_res;
					entry.r1  = mk_res(KIND_END, 1'b0, 8'h00, 1'b1, 1'b0);
					entry.two = 1'b1;
				end
				default: begin
					entry.r0 = mk_res(KIND_END, 1'b0, 8'h00, 1'b1, 1'b0);
				end
			endcase
		end else begin
			unique case (mode_q)
				MODE_STR: begin
					n1 = 1'b1;
					if (in_byte == CH_QUOTE) begin
						entry.r0 = mk_res(KIND_STR, 1'b0, 8'h00, 1'b1, 1'b0);
						mode_d   = MODE_IDLE;
					end else if (in_byte == CH_BSL) begin
						n1     = 1'b0;
						mode_d = MODE_ESC;
					end else begin
						entry.r0 = mk_res(KIND_STR, 1'b1, in_byte, 1'b0, 1'b0);
					end
				end
				MODE_ESC: begin
					n1 = 1'b1;
					if ((in_byte == CH_QUOTE) || (in_byte == CH_BSL)) begin
						entry.r0 = mk_res(KIND_STR, 1'b1, in_byte, 1'b0, 1'b0);
						mode_d   = MODE_STR;
					end else begin
						entry.r0 = mk_res(KIND_ERR, 1'b0, 8'h00, 1'b1, 1'b0);
						mode_d   = MODE_IDLE;
					end
				end
				MODE_NUM: begin
					n1 = 1'b1;
					if (num_cont(in_byte)) begin
						entry.r0 = mk_res(KIND_NUM, 1'b1, in_byte, 1'b0, 1'b0);
					end else begin
						entry.r0 = mk_res(KIND_NUM, 1'b0, 8'h00, 1'b1, 1'b0);
						fresh    = 1'b1;
					end
				end
				MODE_WORD: begin
					if (is_lower(in_byte)) begin
						if ((len_q >= word_len(guess_q)) ||
							(in_byte != word_char(guess_q, len_q)))
							mis_d = 1'b1;
						if (len_q != 3'd7)
							len_d = len_q + 3'd1;
					end else begin
						n1       = 1'b1;
						entry.r0 = word_res;
						fresh    = 1'b1;
					end
				end
				default: begin
					fresh = 1'b1;
				end
			endcase
			if (fresh) begin
				mode_d = fr_mode;
				if (fr_word) begin
					guess_d = (in_byte == "t") ? GUESS_TRUE :
						((in_byte == "f") ? GUESS_FALSE : GUESS_NULL);
					len_d   = 3'd1;
					mis_d   = 1'b0;
				end
				if (fr_has) begin
					if (n1) begin
						entry.r1  = fr_res;
						entry.two = 1'b1;
					end else begin
						entry.r0 = fr_res;
					end
				end
			end
			push = n1 || (fresh && fr_has);
		end
		push = push && in_accept;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			guess_q <= GUESS_TRUE;
			len_q   <= 3'd0;
			mis_q   <= 1'b0;
		end else if (in_accept) begin
			mode_q  <= mode_d;
			guess_q <= guess_d;
			len_q   <= len_d;
			mis_q   <= mis_d;
		end
	end

endmodule
`default_nettype wire

// File: hdl/jtl_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jtl_queue
// Short FIFO of result entries between the lexer and the output stage.
// ----------------------------------------------------------------------------
module jtl_queue #(
	parameter int DEPTH = 4
) (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            push,
	input  jtl_pkg::qent_t wr_entry,
	input  wire            pop,
	output jtl_pkg::qent_t rd_entry,
	output logic           full,
	output logic           empty
);
	import jtl_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	qent_t            mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign rd_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |-> !full) else $error("queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("queue underflow");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH)) else $error("queue count out of range");

endmodule
`default_nettype wire

// File: hdl/jtl_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jtl_back
// Output stage: unpacks queue entries into single result transactions.
// ----------------------------------------------------------------------------
module jtl_back (
	input  wire            clk,
	input  wire            arst_n,
	input  jtl_pkg::qent_t entry,
	input  wire            q_empty,
	output logic           pop,
	output logic           out_valid,
	input  wire            out_ready,
	output jtl_pkg::res_t  out_res
);
	import jtl_pkg::*;

	logic out_valid_q;
	res_t out_q;
	logic pend_q;
	res_t pend_res_q;
	logic advance;

	assign advance   = !out_valid_q || out_ready;
	assign pop       = advance && !pend_q && !q_empty;
	assign out_valid = out_valid_q;
	assign out_res   = out_q;

	always_ff @(posedge clk) begin
		if (advance) begin
			if (pend_q) begin
				out_q <= pend_res_q;
			end else if (!q_empty) begin
				out_q      <= entry.r0;
				pend_res_q <= entry.r1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pend_q      <= 1'b0;
		end else if (advance) begin
			if (pend_q) begin
				out_valid_q <= 1'b1;
				pend_q      <= 1'b0;
			end else begin
				out_valid_q <= !q_empty;
				pend_q      <= !q_empty && entry.two;
			end
		end
	end

	a_pend_has_out: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> out_valid_q) else $error("second result without first");

endmodule
`default_nettype wire

// File: hdl/json_token_lexer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// json_token_lexer
// Byte-stream JSON lexer emitting one result per string or number character and one closing each token.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: s_tdata carries one text byte, s_tlast marks end of input
//   (the byte is then ignored). Output stream: one transaction per result;
//   m_tuser gives the token kind and whether m_tdata carries a character,
//   m_tlast closes the token.
// Throughput: one input byte per cycle while s_tready is high; a byte that causes
//   two results (a number or word closed by a byte with a result of its own, or
//   by end of input) sends both through the output in turn; the entry queue absorbs
//   occasional ones, a steady run of them drops s_tready.
// Path: the results of a byte are written to the entry queue at the edge that
//   takes the byte, then loaded from the queue into the output register.
// Reset: the lexer returns to idle between tokens, the queue and the output
//   register empty.
// Stall: while m_tready is low the output holds; bytes keep being taken
//   until the QUEUE_DEPTH-entry queue fills, then s_tready drops.
// ----------------------------------------------------------------------------
module json_token_lexer #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [7:0]  s_tdata,   // [7:0] in_byte
	input  wire         s_tlast,   // end_of_input
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [15:0] m_tdata,   // [7:0] char_byte, [8] bool_value
	output logic [3:0]  m_tuser,   // [2:0] token_kind, [3] has_char
	output logic        m_tlast    // token_last
);
	import jtl_pkg::*;

	logic  in_accept;
	logic  push;
	logic  pop;
	logic  q_full;
	logic  q_empty;
	qent_t wr_entry;
	qent_t rd_entry;
	res_t  out_res;

	assign s_tready  = !q_full;
	assign in_accept = s_tvalid && !q_full;

	jtl_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_accept (in_accept),
		.in_byte   (s_tdata),
		.in_end    (s_tlast),
		.push      (push),
		.entry     (wr_entry)
	);

	jtl_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (wr_entry),
		.pop      (pop),
		.rd_entry (rd_entry),
		.full     (q_full),
		.empty    (q_empty)
	);

	jtl_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.entry     (rd_entry),
		.q_empty   (q_empty),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res)
	);

	assign m_tdata = {7'b0, out_res.bool_value, out_res.char_byte};
	assign m_tuser = {out_res.has_char, out_res.token_kind};
	assign m_tlast = out_res.token_last;

endmodule
`default_nettype wire

// File: tb/sv/tb_json_token_lexer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_json_token_lexer
// Self-checking bench for the byte-stream JSON lexer. Bytes are pushed in
// through the input stream, a model of the lexer inside the bench predicts
// the result transactions, and every output transaction is compared field
// by field. A short directed run is followed by random JSON-like text under
// three idle patterns on the input and output streams.
// ----------------------------------------------------------------------------
module tb_json_token_lexer;
	import jtl_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int MAX_REPORTS = 10;
	localparam string NUM_CHARS = "0123456789abcdefABCDEF.+-";
	localparam string SEP_CHARS = " ,]}:";

	typedef enum logic [2:0] {
		LX_IDLE,
		LX_STR,
		LX_ESC,
		LX_NUM,
		LX_WORD
	} lex_mode_e;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic [3:0]  m_tuser;
	logic        m_tlast;

	json_token_lexer u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// lexer model state
	lex_mode_e  lx_mode = LX_IDLE;
	logic [1:0] wd_guess = 2'd0;
	logic [2:0] wd_len = 3'd0;
	logic       wd_miss = 1'b0;

	res_t exp_tokens[$];

	int src_idle_pct = 0;
	int sink_idle_pct = 0;
	int bytes_sent = 0;
	int ends_sent = 0;
	int results_seen = 0;
	int error_tokens = 0;
	int fail_count = 0;
	int cycles = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				exp_tokens.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else
			m_tready <= ($urandom_range(99) >= sink_idle_pct);
	end

	function automatic void add_token(logic [2:0] kind, logic has, logic [7:0] ch,
		logic last, logic bv);
		res_t r;
		r.token_kind = kind;
		r.has_char   = has;
		r.char_byte  = has ? ch : 8'h00;
		r.token_last = last;
		r.bool_value = bv;
		exp_tokens = {exp_tokens, r};
	endfunction

	function automatic string word_spelling(logic [1:0] g);
		case (g)
			GUESS_TRUE:  return "true";
			GUESS_FALSE: return "false";
			GUESS_NULL:  return "null";
			default:     return "";
		endcase
	endfunction

	function automatic void close_word_token();
		string w;
		w = word_spelling(wd_guess);
		if (wd_miss || w.len() == 0 || int'(wd_len) != w.len())
			add_token(KIND_ERR, 1'b0, 8'h00, 1'b1, 1'b0);
		else if (wd_guess == GUESS_NULL)
			add_token(KIND_NULL, 1'b0, 8'h00, 1'b1, 1'b0);
		else
			add_token(KIND_BOOL, 1'b0, 8'h00, 1'b1, wd_guess == GUESS_TRUE);
		lx_mode = LX_IDLE;
	endfunction

	function automatic void open_token(logic [7:0] c);
		lx_mode = LX_IDLE;
		if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0D))
			return;
		if (c == CH_QUOTE) begin
			lx_mode = LX_STR;
		end else if (c inside {"+", "-", ["0":"9"]}) begin
			lx_mode = LX_NUM;
			add_token(KIND_NUM, 1'b1, c, 1'b0, 1'b0);
		end else if (c inside {"t", "f", "n"}) begin
			lx_mode = LX_WORD;
			wd_guess = (c == "t") ? GUESS_TRUE : ((c == "f") ? GUESS_FALSE : GUESS_NULL);
			wd_len = 3'd1;
			wd_miss = 1'b0;
		end else if (c inside {"{", "}", "[", "]", ":", ","}) begin
			add_token(KIND_OP, 1'b1, c, 1'b1, 1'b0);
		end else begin
			add_token(KIND_ERR, 1'b0, 8'h00, 1'b1, 1'b0);
		end
	endfunction

	function automatic void predict_tokens(logic [7:0] c, logic eoi);
		string w;
		if (eoi) begin
			case (lx_mode)
				LX_STR, LX_ESC: add_token(KIND_ERR, 1'b0, 8'h00, 1'b1, 1'b0);
				LX_NUM: begin
					add_token(KIND_NUM, 1'b0, 8'h00, 1'b1, 1'b0);
					add_token(KIND_END, 1'b0, 8'h00, 1'b1, 1'b0);
				end
				LX_WORD: begin
					close_word_token();
					add_token(KIND_END, 1'b0, 8'h00, 1'b1, 1'b0);
				end
				default: add_token(KIND_END, 1'b0, 8'h00, 1'b1, 1'b0);
			endcase
			lx_mode = LX_IDLE;
			return;
		end
		case (lx_mode)
			LX_STR: begin
				if (c == CH_QUOTE) begin
					add_token(KIND_STR, 1'b0, 8'h00, 1'b1, 1'b0);
					lx_mode = LX_IDLE;
				end else if (c == CH_BSL) begin
					lx_mode = LX_ESC;
				end else begin
					add_token(KIND_STR, 1'b1, c, 1'b0, 1'b0);
				end
			end
			LX_ESC: begin
				if (c == CH_QUOTE || c == CH_BSL) begin
					add_token(KIND_STR, 1'b1, c, 1'b0, 1'b0);
					lx_mode = LX_STR;
				end else begin
					add_token(KIND_ERR, 1'b0, 8'h00, 1'b1, 1'b0);
					lx_mode = LX_IDLE;
				end
			end
			LX_NUM: begin
				if (c inside {["0":"9"], ["a":"f"], ["A":"F"], ".", "+", "-"}) begin
					add_token(KIND_NUM, 1'b1, c, 1'b0, 1'b0);
				end else begin
					add_token(KIND_NUM, 1'b0, 8'h00, 1'b1, 1'b0);
					open_token(c);
				end
			end
			LX_WORD: begin
				if (c >= "a" && c <= "z") begin
					w = word_spelling(wd_guess);
					if (int'(wd_len) >= w.len() || c != w[wd_len])
						wd_miss = 1'b1;
					if (wd_len < 3'd7)
						wd_len = wd_len + 3'd1;
				end else begin
					close_word_token();
					open_token(c);
				end
			end
			default: open_token(c);
		endcase
	endfunction

	task automatic note_failure(input string msg);
		fail_count++;
		if (fail_count <= MAX_REPORTS)
			$display("MISMATCH @%0t: %s", $realtime, msg);
	endtask

	always @(posedge clk) begin
		res_t got;
		res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.token_kind = m_tuser[2:0];
			got.has_char   = m_tuser[3];
			got.char_byte  = m_tdata[7:0];
			got.token_last = m_tlast;
			got.bool_value = m_tdata[8];
			results_seen++;
			if (got.token_kind == KIND_ERR)
				error_tokens++;
			if (exp_tokens.size() == 0) begin
				note_failure($sformatf("unexpected result kind=%0d has=%0d ch=%02h last=%0d bv=%0d",
					got.token_kind, got.has_char, got.char_byte, got.token_last,
					got.bool_value));
			end else begin
				want = exp_tokens.pop_front();
				if (got !== want)
					note_failure($sformatf({"expected kind=%0d has=%0d ch=%02h last=%0d bv=%0d, ",
						"got kind=%0d has=%0d ch=%02h last=%0d bv=%0d"},
						want.token_kind, want.has_char, want.char_byte, want.token_last,
						want.bool_value, got.token_kind, got.has_char, got.char_byte,
						got.token_last, got.bool_value));
			end
		end
	end

	task automatic send_item(input logic [7:0] b, input logic eoi);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= eoi;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predict_tokens(b, eoi);
		bytes_sent++;
		if (eoi)
			ends_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_item(s[i], 1'b0);
	endtask

	task automatic send_end();
		send_item(8'($urandom_range(255)), 1'b1);
	endtask

	// broken token: cut it off with an end mark now and then
	function automatic logic cut_short();
		return $urandom_range(99) < 3;
	endfunction

	task automatic send_random_string();
		logic [7:0] c;
		int n;
		int r;
		send_item(CH_QUOTE, 1'b0);
		n = $urandom_range(6);
		for (int i = 0; i < n; i++) begin
			if (cut_short()) begin
				send_end();
				return;
			end
			r = $urandom_range(99);
			if (r < 8) begin
				send_item(CH_BSL, 1'b0);
				send_item($urandom_range(1) ? CH_QUOTE : CH_BSL, 1'b0);
			end else if (r < 11) begin
				send_item(CH_BSL, 1'b0);
				send_item(8'($urandom_range(255)), 1'b0);
			end else begin
				c = 8'($urandom_range(255));
				if (c == CH_QUOTE || c == CH_BSL)
					c = "a";
				send_item(c, 1'b0);
			end
		end
		if ($urandom_range(99) < 4)
			send_end();
		else
			send_item(CH_QUOTE, 1'b0);
	endtask

	task automatic send_random_number();
		int n;
		case ($urandom_range(2))
			0: send_item("-", 1'b0);
			1: send_item("+", 1'b0);
			default: send_item(8'("0" + $urandom_range(9)), 1'b0);
		endcase
		n = $urandom_range(6);
		for (int i = 0; i < n; i++) begin
			if (cut_short()) begin
				send_end();
				return;
			end
			send_item(NUM_CHARS[$urandom_range(NUM_CHARS.len() - 1)], 1'b0);
		end
	endtask

	task automatic send_random_word();
		string w;
		int pos;
		w = word_spelling(2'($urandom_range(2)));
		if ($urandom_range(99) < 30) begin
			case ($urandom_range(2))
				0: begin
					pos = $urandom_range(w.len() - 1, 1);
					w[pos] = 8'("a" + $urandom_range(25));
				end
				1: begin
					pos = $urandom_range(5, 1);
					for (int i = 0; i < pos; i++)
						w = {w, string'(8'("a" + $urandom_range(25)))};
				end
				default: w = w.substr(0, $urandom_range(w.len() - 2));
			endcase
		end
		for (int i = 0; i < w.len(); i++) begin
			if (i > 0 && cut_short()) begin
				send_end();
				return;
			end
			send_item(w[i], 1'b0);
		end
	endtask

	task automatic send_random_token();
		int r;
		r = $urandom_range(99);
		if (r < 15) begin
			repeat ($urandom_range(3, 1))
				send_item($urandom_range(3) == 0 ? 8'h20 : 8'($urandom_range(13, 9)), 1'b0);
		end else if (r < 35) begin
			send_random_string();
		end else if (r < 72) begin
			if (r < 55)
				send_random_number();
			else
				send_random_word();
			if ($urandom_range(99) < 70)
				send_item(SEP_CHARS[$urandom_range(SEP_CHARS.len() - 1)], 1'b0);
		end else if (r < 87) begin
			send_item(SEP_CHARS[$urandom_range(4, 1)], 1'b0);
			if ($urandom_range(1))
				send_item($urandom_range(1) ? "{" : "[", 1'b0);
		end else if (r < 95) begin
			send_item(8'($urandom_range(255)), 1'b0);
		end else begin
			send_end();
		end
	endtask

	task automatic run_random(input int n);
		int target;
		target = bytes_sent + n;
		while (bytes_sent < target)
			send_random_token();
	endtask

	task automatic test_operators();
		send_text("{}[]:,");
	endtask

	task automatic test_strings();
		send_text({"\"\\\"\\\\", string'(8'hFF), "\""});
		send_text("\"\\q");
	endtask

	task automatic test_numbers_and_words();
		send_text("-Ftruen");
		send_end();
	endtask

	task automatic test_end_cases();
		send_item(CH_QUOTE, 1'b0);
		send_end();
		send_item("5", 1'b0);
		send_end();
		send_item("~", 1'b0);
		send_end();
	endtask

	task automatic test_random_slow_sink();
		src_idle_pct  = 26;
		sink_idle_pct = 79;
		run_random(480);
	endtask

	task automatic test_random_slow_source();
		src_idle_pct  = 79;
		sink_idle_pct = 26;
		run_random(480);
	endtask

	task automatic test_random_full_rate();
		src_idle_pct  = 0;
		sink_idle_pct = 0;
		run_random(490);
	endtask

	initial begin
		src_idle_pct  = 26;
		sink_idle_pct = 79;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_operators();
		test_strings();
		test_numbers_and_words();
		test_end_cases();
		test_random_slow_sink();
		test_random_slow_source();
		test_random_full_rate();

		s_tvalid <= 1'b0;
		while (exp_tokens.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		fail_count += exp_tokens.size();

		$display("Sent %0d bytes (%0d end marks) under three idle patterns;",
			bytes_sent, ends_sent);
		$display("checked %0d result transactions, %0d of them error tokens.",
			results_seen, error_tokens);
		if (fail_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d failures", fail_count);
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
`default_nettype wire
